@@ rtl/pidc_pkg.sv @@
`timescale 1ns / 1ps
package pidc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned TimeW = 31;
  localparam int unsigned DivW = 49;
  localparam int unsigned DivCntW = 6;
  localparam int unsigned CfgIdxW = 3;

  typedef logic signed [DataW-1:0] q_t;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_ZERO_STEP = 2'd1,
    STATUS_BAD_LIMIT = 2'd2
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P = 3'd0,
    REG_GAIN_I = 3'd1,
    REG_GAIN_D = 3'd2,
    REG_DRIVE_LOWER = 3'd3,
    REG_DRIVE_UPPER = 3'd4,
    REG_ACCUM_LOWER = 3'd5,
    REG_ACCUM_UPPER = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_ERROR,
    OP_ACCUM,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D
  } op_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic commit;
    logic run;
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

  function automatic q_t sat32(input logic signed [66:0] x);
    if (x > 67'sd2147483647) begin
      return q_t'(32'h7fffffff);
    end else if (x < -67'sd2147483648) begin
      return q_t'(32'h80000000);
    end else begin
      return q_t'(x[31:0]);
    end
  endfunction

endpackage

@@ rtl/pid_controller_clamped.sv @@
`timescale 1ns / 1ps
// clamped pid controller, signed q16.16. the derivative quotient of an update
// comes from a restoring divider that resolves one bit per cycle over 49 bits,
// and the three gain products share one multiplier. clear, zero step time and
// bad limit items answer in the cycle after they are accepted.
module pid_controller_clamped (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic signed [31:0]  target,
  input  logic signed [31:0]  measured,
  input  logic [30:0]         step_time,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  drive,
  output logic [1:0]          status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import pidc_pkg::*;

  q_t gain_p, gain_i, gain_d, drive_lower, drive_upper, accum_lower, accum_upper;
  cmd_t ctl;
  stat_t st;
  logic bad_limits;

  assign cfg_ready = 1'b1;
  assign bad_limits = (drive_lower > drive_upper) || (accum_lower > accum_upper);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
      drive_lower <= q_t'(32'h80000000);
      drive_upper <= q_t'(32'h7fffffff);
      accum_lower <= q_t'(32'h80000000);
      accum_upper <= q_t'(32'h7fffffff);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_P: gain_p <= cfg_data;
        REG_GAIN_I: gain_i <= cfg_data;
        REG_GAIN_D: gain_d <= cfg_data;
        REG_DRIVE_LOWER: drive_lower <= cfg_data;
        REG_DRIVE_UPPER: drive_upper <= cfg_data;
        REG_ACCUM_LOWER: accum_lower <= cfg_data;
        REG_ACCUM_UPPER: accum_upper <= cfg_data;
        default: ;
      endcase
    end
  end

  pidc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .cmd, .step_time, .bad_limits, .st, .ctl,
    .out_valid, .out_ready, .status
  );

  pidc_datapath u_dp (
    .clk, .ctl, .st, .target, .measured, .step_time, .gain_p, .gain_i, .gain_d,
    .drive_lower, .drive_upper, .accum_lower, .accum_upper, .rst, .result(drive)
  );

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accepted while result pending");
  a_bad_status: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && bad_limits) |=> (out_valid && status == STATUS_BAD_LIMIT))
    else $error("bad limits not reported");
  a_zero_drive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (drive == '0)) else $error("drive nonzero on error");

endmodule

@@ rtl/pidc_datapath.sv @@
`timescale 1ns / 1ps
module pidc_datapath (
  input  logic                  clk,
  input  pidc_pkg::cmd_t        ctl,
  output pidc_pkg::stat_t       st,
  input  logic signed [31:0]    target,
  input  logic signed [31:0]    measured,
  input  logic [30:0]           step_time,
  input  logic signed [31:0]    gain_p,
  input  logic signed [31:0]    gain_i,
  input  logic signed [31:0]    gain_d,
  input  logic signed [31:0]    drive_lower,
  input  logic signed [31:0]    drive_upper,
  input  logic signed [31:0]    accum_lower,
  input  logic signed [31:0]    accum_upper,
  input  logic                  rst,
  output logic signed [31:0]    result
);
  import pidc_pkg::*;

  q_t tgt, meas, err, accum, last_error, deriv, accum_new;
  logic [TimeW-1:0] dt;
  logic [DivW-1:0] quo, rem_mag;
  logic [DivW:0] rem;
  logic neg;
  logic [DivCntW-1:0] cnt;
  logic signed [66:0] sum;
  logic signed [63:0] prod;
  logic signed [66:0] acc_sum;
  logic signed [33:0] diff;
  logic [DivW:0] trial;
  logic signed [66:0] dq;
  q_t sum_sat;

  assign diff = 34'(err) - 34'(last_error);
  assign acc_sum = 67'(accum) + 67'(prod >>> 16);
  assign trial = {rem[DivW-1:0], rem_mag[DivW-1]} - {{(DivW-TimeW+1){1'b0}}, dt};
  assign dq = neg ? ((rem != '0) ? -67'(quo) - 67'sd1 : -67'(quo)) : 67'(quo);
  assign st.div_done = (cnt == DivCntW'(DivW - 1));
  assign sum_sat = sat32(sum);

  always_comb begin
    accum_new = sat32(acc_sum);
    if (accum_new < accum_lower) accum_new = accum_lower;
    else if (accum_new > accum_upper) accum_new = accum_upper;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
      last_error <= '0;
    end else if (ctl.clear) begin
      accum <= '0;
      last_error <= '0;
    end else if (ctl.commit) begin
      last_error <= err;
    end else if (ctl.run && ctl.op == OP_DIV_START) begin
      accum <= accum_new;
    end
    if (ctl.load) begin
      tgt <= target;
      meas <= measured;
      dt <= step_time;
      sum <= '0;
    end
    if (ctl.commit) begin
      if (sum_sat < drive_lower) result <= drive_lower;
      else if (sum_sat > drive_upper) result <= drive_upper;
      else result <= sum_sat;
    end else if (ctl.clear || ctl.load) begin
      result <= '0;
    end
    if (ctl.run) begin
      unique case (ctl.op)
        OP_ERROR: begin
          err <= sat32(67'(tgt) - 67'(meas));
        end
        OP_ACCUM: begin
          prod <= 64'(err) * $signed({33'd0, dt});
        end
        OP_DIV_START: begin
          prod <= 64'(err) * 64'(gain_p);
          neg <= diff[33];
          rem_mag <= DivW'(diff[33] ? -diff : diff) << 16;
          rem <= '0;
          quo <= '0;
          cnt <= '0;
        end
        OP_DIV_STEP: begin
          if (!trial[DivW]) begin
            rem <= trial;
            quo <= {quo[DivW-2:0], 1'b1};
          end else begin
            rem <= {rem[DivW-1:0], rem_mag[DivW-1]};
            quo <= {quo[DivW-2:0], 1'b0};
          end
          rem_mag <= {rem_mag[DivW-2:0], 1'b0};
          cnt <= cnt + 1'b1;
        end
        OP_DIV_END: begin
          deriv <= sat32(dq);
        end
        OP_MUL_P: begin
          sum <= sum + 67'(prod >>> 16);
          prod <= 64'(accum) * 64'(gain_i);
        end
        OP_MUL_I: begin
          sum <= sum + 67'(prod >>> 16);
          prod <= 64'(deriv) * 64'(gain_d);
        end
        OP_MUL_D: begin
          sum <= sum + 67'(prod >>> 16);
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/pidc_ctrl.sv @@
`timescale 1ns / 1ps
module pidc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cmd,
  input  logic [30:0]     step_time,
  input  logic            bad_limits,
  input  pidc_pkg::stat_t st,
  output pidc_pkg::cmd_t  ctl,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      status
);
  import pidc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_ACC, S_DSTART, S_DSTEP, S_DEND, S_MP, S_MI, S_MD, S_DONE, S_OUT
  } state_t;

  state_t state;
  logic acc;

  assign acc = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    ctl = '0;
    ctl.load = acc;
    ctl.clear = acc && !bad_limits && cmd;
    ctl.run = 1'b1;
    unique case (state)
      S_ERR: ctl.op = OP_ERROR;
      S_ACC: ctl.op = OP_ACCUM;
      S_DSTART: ctl.op = OP_DIV_START;
      S_DSTEP: ctl.op = OP_DIV_STEP;
      S_DEND: ctl.op = OP_DIV_END;
      S_MP: ctl.op = OP_MUL_P;
      S_MI: ctl.op = OP_MUL_I;
      S_MD: ctl.op = OP_MUL_D;
      default: ctl.run = 1'b0;
    endcase
    ctl.commit = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      status <= STATUS_OK;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (bad_limits) begin
              status <= STATUS_BAD_LIMIT;
              out_valid <= 1'b1;
            end else if (cmd) begin
              status <= STATUS_OK;
              out_valid <= 1'b1;
            end else if (step_time == '0) begin
              status <= STATUS_ZERO_STEP;
              out_valid <= 1'b1;
            end else begin
              status <= STATUS_OK;
              state <= S_ERR;
            end
          end
        end
        S_ERR: state <= S_ACC;
        S_ACC: state <= S_DSTART;
        S_DSTART: state <= S_DSTEP;
        S_DSTEP: if (st.div_done) state <= S_DEND;
        S_DEND: state <= S_MP;
        S_MP: state <= S_MI;
        S_MI: state <= S_MD;
        S_MD: state <= S_DONE;
        S_DONE: begin
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ test/pid_controller_clamped_chk.sv @@
`timescale 1ns / 1ps
module pid_controller_clamped_chk
  import pidc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               cmd,
  input  logic signed [31:0] target,
  input  logic signed [31:0] measured,
  input  logic [30:0]        step_time,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] drive,
  input  logic [1:0]         status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] drive;
    status_t status;
  } ctl_result_t;

  ctl_result_t exp_q[$];
  logic signed [63:0] kp, ki, kd, dlo, dhi, alo, ahi, acc, last_err;

  function automatic logic signed [95:0] fdiv(input logic signed [95:0] n,
                                              input logic signed [95:0] d);
    logic signed [95:0] q;
    q = n / d;
    if (n % d != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [95:0] sat(input logic signed [95:0] x);
    if (x > 96'sd2147483647) return 96'sd2147483647;
    if (x < -96'sd2147483648) return -96'sd2147483648;
    return x;
  endfunction

  function automatic logic signed [95:0] clip(input logic signed [95:0] x,
                                              input logic signed [63:0] lo,
                                              input logic signed [63:0] hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  task automatic predict_update();
    ctl_result_t r;
    logic signed [95:0] e, dt, de, s, a;
    r = '{drive: '0, status: STATUS_OK};
    dt = {65'd0, step_time};
    if (dlo > dhi || alo > ahi) begin
      r.status = STATUS_BAD_LIMIT;
    end else if (cmd) begin
      acc = 0;
      last_err = 0;
    end else if (dt == 0) begin
      r.status = STATUS_ZERO_STEP;
    end else begin
      e = sat(96'(target) - 96'(measured));
      a = clip(sat(96'(acc) + fdiv(e * dt, 65536)), alo, ahi);
      acc = a[63:0];
      de = sat(fdiv((e - 96'(last_err)) * 65536, dt));
      s = fdiv(96'(kp) * e, 65536) + fdiv(96'(ki) * 96'(acc), 65536)
        + fdiv(96'(kd) * de, 65536);
      s = clip(sat(s), dlo, dhi);
      last_err = e[63:0];
      r.drive = s[31:0];
    end
    exp_q.push_back(r);
  endtask

  assign pending = exp_q.size();

  always @(posedge clk) begin
    ctl_result_t e;
    if (rst) begin
      kp = 0; ki = 0; kd = 0;
      dlo = -64'sd2147483648; dhi = 64'sd2147483647;
      alo = -64'sd2147483648; ahi = 64'sd2147483647;
      acc = 0; last_err = 0;
      fail_count <= 0;
      exp_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_GAIN_P: kp = $signed(cfg_data);
          REG_GAIN_I: ki = $signed(cfg_data);
          REG_GAIN_D: kd = $signed(cfg_data);
          REG_DRIVE_LOWER: dlo = $signed(cfg_data);
          REG_DRIVE_UPPER: dhi = $signed(cfg_data);
          REG_ACCUM_LOWER: alo = $signed(cfg_data);
          REG_ACCUM_UPPER: ahi = $signed(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_update();
      if (out_valid && out_ready) begin
        if (exp_q.size() == 0) begin
          $display("%0t: unexpected transaction drive=%0d status=%0d", $time, drive, status);
          fail_count <= fail_count + 1;
        end else begin
          e = exp_q.pop_front();
          if (e.drive !== drive || e.status !== status) begin
            $display("%0t: mismatch expected drive=%0d status=%0d actual drive=%0d status=%0d",
                     $time, e.drive, e.status, drive, status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ test/pid_controller_clamped_tb.sv @@
`timescale 1ns / 1ps
module pid_controller_clamped_tb;
  import pidc_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, cmd = 0;
  logic signed [31:0] target = 0, measured = 0, drive;
  logic [30:0] step_time = 0;
  logic out_valid, out_ready = 0;
  logic [1:0] status;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  int fail_count, pending;
  int send_idle = 0, recv_idle = 0;
  bit hold_off = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  pid_controller_clamped u_top (.*);

  pid_controller_clamped_chk u_chk (.*);

  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  initial begin
    repeat (30) @(negedge clk);
    forever begin
      repeat ($urandom_range(1500, 600)) @(negedge clk);
      hold_off = 1;
      repeat (400) @(negedge clk);
      hold_off = 0;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic send_item(input logic c, input logic [31:0] t, input logic [31:0] m,
                           input logic [30:0] dt);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    cmd <= c;
    target <= t;
    measured <= m;
    step_time <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_q();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(8 << 16)) - (4 << 16);
    endcase
  endfunction

  function automatic logic [30:0] rnd_dt();
    case ($urandom_range(9))
      0: return 31'd0;
      1: return 31'($urandom);
      2: return 31'd1;
      default: return 31'($urandom_range(1 << 16, 1));
    endcase
  endfunction

  task automatic set_config(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
                            input logic [31:0] dl, input logic [31:0] dh,
                            input logic [31:0] al, input logic [31:0] ah);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_DRIVE_LOWER, dl);
    write_reg(REG_DRIVE_UPPER, dh);
    write_reg(REG_ACCUM_LOWER, al);
    write_reg(REG_ACCUM_UPPER, ah);
  endtask

  task automatic random_phase(input int n);
    repeat (n) begin
      if ($urandom_range(19) == 0) send_item(1, $urandom, $urandom, 31'($urandom));
      else send_item(0, rnd_q(), rnd_q(), rnd_dt());
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 0;
    repeat (2) @(negedge clk);
    // directed
    set_config(32'h00010000, 32'h00008000, 32'h00000800,
               32'h80000000, 32'h7fffffff, 32'hfff00000, 32'h00100000);
    send_item(0, 32'h7fffffff, 32'h80000000, 31'h7fffffff);
    send_item(0, 32'h80000000, 32'h7fffffff, 31'd1);
    send_item(0, 32'h00010000, 32'h0, 31'h0);
    send_item(0, 32'h00020000, 32'h00010000, 31'h00010000);
    send_item(1, 32'hffffffff, 32'hffffffff, 31'h7fffffff);
    send_item(0, 32'h0, 32'h00030000, 31'h00008000);
    send_item(0, 32'hffffffff, 32'h0, 31'h00000100);
    drain();
    write_reg(REG_DRIVE_LOWER, 32'h00010000);
    write_reg(REG_DRIVE_UPPER, 32'h0);
    send_item(0, 32'h00010000, 32'h0, 31'h00010000);
    send_item(1, 32'h0, 32'h0, 31'h0);
    drain();
    write_reg(REG_DRIVE_UPPER, 32'h00020000);
    write_reg(REG_ACCUM_LOWER, 32'h7fffffff);
    write_reg(REG_ACCUM_UPPER, 32'h80000000);
    send_item(0, 32'h00010000, 32'h0, 31'h0);
    drain();
    write_reg(REG_UNUSED, 32'h12345678);
    // random phases
    send_idle = 26; recv_idle = 70;
    set_config(32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    random_phase(230);
    drain();
    send_idle = 70; recv_idle = 26;
    set_config($urandom_range(1 << 18), $urandom_range(1 << 16), $urandom_range(1 << 12),
               32'hfffc0000, 32'h00040000, 32'hfffe0000, 32'h00020000);
    random_phase(230);
    drain();
    send_idle = 0; recv_idle = 0;
    set_config($urandom, $urandom, $urandom,
               32'hffff0000, 32'h00010000, 32'h80000000, 32'h7fffffff);
    random_phase(230);
    drain();
    if (fail_count == 0) $display("[pid_controller_clamped] OK");
    else $display("[pid_controller_clamped] ERROR");
    $finish;
  end

  initial begin
    #40ms;
    $display("[pid_controller_clamped] ERROR");
    $finish;
  end

endmodule
